>>> sv/bba_pkg.sv
// shared types and codes of the bitmap block allocator
`timescale 1ns / 1ps

package bba_pkg;

    // block counts and block indexes
    localparam int BLK_W = 13;
    // start block field width
    localparam int IDX_W = 12;
    // action field width
    localparam int ACT_W = 2;
    // status field width
    localparam int STS_W = 2;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd3;

    localparam logic [STS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STS_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STS_W-1:0] ST_REJECT = 2'd2;

    // one step of the first-fit search
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic             last;
        logic [BLK_W-1:0] start;
    } t_scan_res;

    // run to be marked, inclusive bounds
    typedef struct packed {
        logic             set_used;
        logic [BLK_W-1:0] lo_blk;
        logic [BLK_W-1:0] hi_blk;
    } t_mark_cmd;

    // number of bits that flipped in one written word
    typedef struct packed {
        logic             vld;
        logic [BLK_W-1:0] cnt;
    } t_pop;

endpackage

>>> sv/bba_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/bba_scan.sv
// first-fit free run search, one bitmap word per cycle, two stages
`timescale 1ns / 1ps

module bba_scan #(
    parameter int WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_strobe,
    input  logic [WORD_BITS-1:0]       i_word,
    input  logic [bba_pkg::BLK_W-1:0]  i_base,
    input  logic                       i_last,
    input  logic [$clog2(WORD_BITS)-1:0] i_lim_bit,
    input  logic [bba_pkg::BLK_W-1:0]  i_len,
    output bba_pkg::t_scan_res         o_res
);

    import bba_pkg::*;

    localparam int LB = $clog2(WORD_BITS);
    localparam int CW = LB + 1;

    logic [WORD_BITS-1:0] w_free;
    logic [CW-1:0]        w_cs [LB+1][WORD_BITS];

    logic                 r_v1;
    logic                 r_last;
    logic [BLK_W-1:0]     r_base;
    logic [CW-1:0]        r_c [WORD_BITS];
    logic [BLK_W-1:0]     r_run;

    logic [WORD_BITS-1:0] w_hit;
    logic [BLK_W-1:0]     w_run [WORD_BITS];
    logic [LB-1:0]        w_sel;
    logic [BLK_W-1:0]     n_run;

    // stage 1: free runs ending at each bit, within the word, by doubling
    always_comb begin
        w_free = ~i_word;
        if (i_last) begin
            w_free = w_free & ({WORD_BITS{1'b1}} >> (LB'(WORD_BITS - 1) - i_lim_bit));
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            w_cs[0][i] = CW'(w_free[i]);
        end
        for (int s = 0; s < LB; s++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                w_cs[s+1][i] = w_cs[s][i];
                if (i >= (1 << s) && w_cs[s][i] == CW'(1 << s)) begin
                    w_cs[s+1][i] = w_cs[s][i] + w_cs[s][i - (1 << s)];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_strobe;
        end
        if (i_strobe) begin
            r_last <= i_last;
            r_base <= i_base;
            for (int i = 0; i < WORD_BITS; i++) begin
                r_c[i] <= w_cs[LB][i];
            end
        end
    end

    // stage 2: add the run carried in from lower words, find the first fit
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            if (r_c[i] == CW'(i + 1)) begin
                w_run[i] = r_run + BLK_W'(i + 1);
            end else begin
                w_run[i] = BLK_W'(r_c[i]);
            end
            w_hit[i] = (w_run[i] >= i_len);
        end
        w_sel = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_sel = LB'(i);
            end
        end
        if (r_c[WORD_BITS-1] == CW'(WORD_BITS)) begin
            n_run = r_run + BLK_W'(WORD_BITS);
        end else begin
            n_run = BLK_W'(r_c[WORD_BITS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_run <= '0;
        end else if (r_v1) begin
            r_run <= n_run;
        end
    end

    assign o_res.vld   = r_v1;
    assign o_res.hit   = |w_hit;
    assign o_res.last  = r_last;
    assign o_res.start = r_base + BLK_W'(w_sel) + BLK_W'(1) - i_len;

endmodule

>>> sv/bba_mark.sv
// run marking of one bitmap word and count of flipped bits
`timescale 1ns / 1ps

module bba_mark #(
    parameter int WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_strobe,
    input  logic [WORD_BITS-1:0]      i_word,
    input  logic [bba_pkg::BLK_W-1:0] i_base,
    input  bba_pkg::t_mark_cmd        i_cmd,
    output logic [WORD_BITS-1:0]      o_word,
    output bba_pkg::t_pop             o_pop
);

    import bba_pkg::*;

    localparam int LB = $clog2(WORD_BITS);

    logic [LB-1:0]        w_lo_bit;
    logic [LB-1:0]        w_hi_bit;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_flip;

    always_comb begin
        w_lo_bit = '0;
        w_hi_bit = LB'(WORD_BITS - 1);
        if ((i_cmd.lo_blk >> LB) == (i_base >> LB)) begin
            w_lo_bit = i_cmd.lo_blk[LB-1:0];
        end
        if ((i_cmd.hi_blk >> LB) == (i_base >> LB)) begin
            w_hi_bit = i_cmd.hi_blk[LB-1:0];
        end
        w_mask = ({WORD_BITS{1'b1}} << w_lo_bit)
               & ({WORD_BITS{1'b1}} >> (LB'(WORD_BITS - 1) - w_hi_bit));
        // block zero never goes free
        if (!i_cmd.set_used && i_base == '0) begin
            w_mask[0] = 1'b0;
        end
        if (i_cmd.set_used) begin
            o_word = i_word | w_mask;
            w_flip = w_mask & ~i_word;
        end else begin
            o_word = i_word & ~w_mask;
            w_flip = w_mask & i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pop.vld <= 1'b0;
        end else begin
            o_pop.vld <= i_strobe;
        end
        o_pop.cnt <= BLK_W'($countones(w_flip));
    end

endmodule

>>> sv/bitmap_block_allocator_core.sv
// top level of the first-fit bitmap block allocator
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// request   in         i_in_valid / o_in_stall i_action, i_first_block, i_run_length
// result    out        o_out_valid / i_out_stall o_status, o_start_block, o_free_blocks
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (total_blocks)
//
// one item at a time; the bitmap ram is read one word per cycle
// allocate: words are scanned up to the first fit, then the words of the run are marked
// allocate with no fit: every word up to total_blocks is scanned
// free, release, reserve: only the run words are read and marked; a rejected item goes straight to the result
// reset and a config write mark every block used by clearing per-word valid bits, no sweep
// a held result stalls only the final step; the next item is taken as soon as the result is out

module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bba_pkg::ACT_W-1:0] i_action,
    input  logic [bba_pkg::IDX_W-1:0] i_first_block,
    input  logic [bba_pkg::BLK_W-1:0] i_run_length,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [bba_pkg::STS_W-1:0] o_status,
    output logic [bba_pkg::IDX_W-1:0] o_start_block,
    output logic [bba_pkg::BLK_W-1:0] o_free_blocks,
    // configuration write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bba_pkg::BLK_W-1:0] i_cfg_data
);

    import bba_pkg::*;

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LB        = $clog2(WORD_BITS);
    localparam int TOT_MAX   = (1 << BLK_W) - 1;
    localparam logic [BLK_W-1:0] TOT_RST =
        BLK_W'((NUM_BLOCKS > TOT_MAX) ? TOT_MAX : NUM_BLOCKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_RESULT
    } t_state;

    t_state               r_state;

    // configuration and counters
    logic [BLK_W-1:0]     r_total;
    logic [BLK_W-1:0]     r_free;
    // per-word written flag; an unwritten word reads as all used
    logic [NUM_WORDS-1:0] r_valid;

    // item context
    logic [BLK_W-1:0]     r_len;
    t_mark_cmd            r_cmd;
    logic [STS_W-1:0]     r_status;
    logic [BLK_W-1:0]     r_start;

    // read sequencer
    logic                 r_issue;
    logic [AW-1:0]        r_raddr;
    logic [AW-1:0]        r_end;
    logic                 r_rd_strobe;
    logic [AW-1:0]        r_rd_addr;
    logic                 r_rd_vld;
    logic                 r_rd_last;

    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_word;
    logic [BLK_W-1:0]     w_base;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_we;
    logic                 w_in_acc;
    logic                 w_reject;
    logic [BLK_W-1:0]     w_tot_m1;
    logic [AW-1:0]        w_last_word;
    logic [BLK_W:0]       w_span;
    logic [BLK_W-1:0]     w_hi_blk;
    logic [BLK_W-1:0]     w_hit_hi;
    logic                 w_out_free;
    logic                 w_fit;
    logic                 w_res_load;
    t_scan_res            w_sres;
    t_pop                 w_pop;

    // a pending config write takes the idle slot first
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !o_out_valid || !i_out_stall;

    // first fit seen by the scan, and result register load
    assign w_fit       = (r_state == S_SCAN) && w_sres.vld && w_sres.hit;
    assign w_res_load  = (r_state == S_RESULT) && w_out_free;

    assign w_tot_m1    = r_total - BLK_W'(1);
    assign w_last_word = AW'(w_tot_m1 >> LB);

    // range checks on the incoming request
    assign w_span   = {1'b0, BLK_W'(i_first_block)} + {1'b0, i_run_length};
    assign w_reject = (i_run_length == '0) || (i_run_length > r_total)
                   || ((i_action != ACT_ALLOC) && (w_span > {1'b0, r_total}));
    assign w_hi_blk = BLK_W'(i_first_block) + i_run_length - BLK_W'(1);
    assign w_hit_hi = w_sres.start + r_len - BLK_W'(1);

    // word as seen by the logic: unwritten words are all used
    assign w_word = r_rd_vld ? w_rdata : {WORD_BITS{1'b1}};
    assign w_base = BLK_W'(r_rd_addr) << LB;
    assign w_we   = r_rd_strobe && (r_state == S_MARK);

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .ADDR_W(AW)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_rd_addr),
        .i_wdata(w_wdata),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    bba_scan #(
        .WORD_BITS(WORD_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_in_acc),
        .i_strobe (r_rd_strobe && (r_state == S_SCAN)),
        .i_word   (w_word),
        .i_base   (w_base),
        .i_last   (r_rd_last),
        .i_lim_bit(w_tot_m1[LB-1:0]),
        .i_len    (r_len),
        .o_res    (w_sres)
    );

    bba_mark #(
        .WORD_BITS(WORD_BITS)
    ) u_mark (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_strobe(w_we),
        .i_word  (w_word),
        .i_base  (w_base),
        .i_cmd   (r_cmd),
        .o_word  (w_wdata),
        .o_pop   (w_pop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= TOT_RST;
            r_free      <= '0;
            r_valid     <= '0;
            r_issue     <= 1'b0;
            r_rd_strobe <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // read pipeline, one word per cycle while issuing; a found fit drops reads in flight
            r_rd_strobe <= r_issue && !w_fit;
            r_rd_addr   <= r_raddr;
            r_rd_vld    <= r_valid[r_raddr];
            r_rd_last   <= (r_raddr == r_end);
            if (r_issue && !w_fit) begin
                r_raddr <= r_raddr + AW'(1);
                if (r_raddr == r_end) begin
                    r_issue <= 1'b0;
                end
            end

            if (w_we) begin
                r_valid[r_rd_addr] <= 1'b1;
            end
            if (w_pop.vld) begin
                if (r_cmd.set_used) begin
                    r_free <= r_free - w_pop.cnt;
                end else begin
                    r_free <= r_free + w_pop.cnt;
                end
            end

            if (w_res_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        // new size: everything used again
                        if (i_cfg_data == '0) begin
                            r_total <= BLK_W'(1);
                        end else if (32'(i_cfg_data) > 32'(NUM_BLOCKS)) begin
                            r_total <= TOT_RST;
                        end else begin
                            r_total <= i_cfg_data;
                        end
                        r_free  <= '0;
                        r_valid <= '0;
                    end else if (w_in_acc) begin
                        r_len        <= i_run_length;
                        r_start      <= '0;
                        r_status     <= w_reject ? ST_REJECT : ST_DONE;
                        r_cmd.lo_blk <= BLK_W'(i_first_block);
                        r_cmd.hi_blk <= w_hi_blk;
                        r_cmd.set_used <= (i_action == ACT_ALLOC) || (i_action == ACT_RESERVE);
                        if (w_reject) begin
                            r_state  <= S_RESULT;
                        end else if (i_action == ACT_ALLOC) begin
                            r_raddr <= '0;
                            r_end   <= w_last_word;
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_raddr <= AW'(BLK_W'(i_first_block) >> LB);
                            r_end   <= AW'(w_hi_blk >> LB);
                            r_issue <= 1'b1;
                            r_state <= S_MARK;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_fit) begin
                        // first fit found: mark the run
                        r_start      <= w_sres.start;
                        r_cmd.lo_blk <= w_sres.start;
                        r_cmd.hi_blk <= w_hit_hi;
                        r_raddr      <= AW'(w_sres.start >> LB);
                        r_end        <= AW'(w_hit_hi >> LB);
                        r_issue      <= 1'b1;
                        r_state      <= S_MARK;
                    end else if (w_sres.vld && w_sres.last) begin
                        r_status <= ST_NOFIT;
                        r_state  <= S_RESULT;
                    end
                end
                S_MARK: begin
                    // wait for the last write and the last count update
                    if (!r_issue && !r_rd_strobe && !w_pop.vld) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (w_res_load) begin
                        o_status      <= r_status;
                        o_start_block <= r_start[IDX_W-1:0];
                        o_free_blocks <= r_free;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // free count can never pass the managed size
    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_total)
        else $error("free count above total blocks");

    // a start block is only reported for a successful allocation
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_start_block == '0))
        else $error("start block set on a failed item");

    // a found run lies inside managed memory
    a_fit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_sres.vld && w_sres.hit)
            |-> ({1'b0, w_sres.start} + {1'b0, r_len} <= {1'b0, r_total}))
        else $error("allocated run beyond total blocks");

    // an accepted item always leaves idle on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted item not started");

endmodule
